>>> hw/rtl/odpa_pkg.sv
package odpa_pkg;

  // orientations per pixel and CORDIC depth
  localparam int NUM_ORIENT   = 8;
  localparam int CORDIC_ITERS = 16;

  localparam int ATAN_LEN  = 24;
  localparam int ITERS_EFF = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
  localparam int ITER_W    = $clog2(ATAN_LEN);
  localparam int OI_W      = $clog2(NUM_ORIENT);

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int SUM_W    = 20;
  localparam int PHASE_W  = 16;

  // harmonic accumulators: 17x16 signed product plus growth over the orientations
  localparam int ACC_W   = SAMPLE_W + COEF_W + OI_W + 1;
  // vectoring datapath: headroom for the CORDIC gain on a diagonal vector
  localparam int CW      = ACC_W + 2;
  // magnitude product split into two partial products
  localparam int LO_W    = 20;
  localparam int HI_W    = CW - LO_W;
  localparam int GAIN_W  = 24;
  localparam int MAGP_W  = CW + GAIN_W;
  localparam int MAG_SHIFT = 39;
  localparam int MAG_W   = MAGP_W - MAG_SHIFT;

  localparam logic [31:0] GAIN_Q24  = 32'd10188014;
  localparam logic [31:0] DEG_SCALE = 32'd45;
  localparam logic [31:0] RAD_SCALE = 32'd3373259426;
  localparam int DEG_SHIFT = 22;
  localparam int RAD_SHIFT = 48;
  localparam logic [SUM_W-1:0] AMP_MAX = '1;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // register map
  localparam logic REG_DEGREE_MODE = 1'b0;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic [NUM_ORIENT-1:0][COEF_W-1:0] coef_tab_t;

  // Q1.15 cos/sin of 2*pi*k/NUM_ORIENT by a Q2.30 rotation CORDIC; elaboration only
  function automatic coef_tab_t build_coef(input bit want_sin);
    coef_tab_t   tab;
    logic [31:0] a;
    logic [31:0] offs;
    bit          flip;
    longint      x, y, z, nx, ny, v, r;
    for (int k = 0; k < NUM_ORIENT; k++) begin
      a    = 32'(((longint'(k) <<< 32) + NUM_ORIENT / 2) / NUM_ORIENT);
      offs = a - 32'h4000_0000;
      flip = offs < 32'h8000_0000;
      if (flip) begin
        a = a - 32'h8000_0000;
      end
      z = a[31] ? (longint'(a) - (64'sd1 <<< 32)) : longint'(a);
      x = 64'sd652032874;
      y = 64'sd0;
      for (int i = 0; i < ATAN_LEN; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - longint'(ATAN_TAB[i]);
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + longint'(ATAN_TAB[i]);
        end
        x = nx;
        y = ny;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      v = want_sin ? y : x;
      if (v >= 0) begin
        r = (v + 16384) >>> 15;
      end else begin
        r = -(((-v) + 16384) >>> 15);
      end
      if (r > 32767) begin
        r = 32767;
      end
      if (r < -32768) begin
        r = -32768;
      end
      tab[k] = COEF_W'(r);
    end
    return tab;
  endfunction

  localparam coef_tab_t COS_TAB = build_coef(1'b0);
  localparam coef_tab_t SIN_TAB = build_coef(1'b1);

endpackage

>>> hw/rtl/orientation_dft_phase_amplitude_unit.sv
// Orientation estimate from the first DFT harmonic of a row of filter magnitudes.
//
// Input channel (in_valid_i/in_ready_o, filter_sample_i): NUM_ORIENT words per
// pixel, orientation 0 first. Each word is taken in a single cycle; sum, maximum
// and the harmonic (real, imag) build up in registers.
// After the last word of a pixel the port drops ready while a shared CORDIC
// add/shift stage iterates once per cycle, then one shared
// 32x32 multiplier runs three passes (two magnitude partial products, one phase
// scale). The result word appears on out_valid_o after the load step, the CORDIC
// iterations, the three multiply passes and the finishing step; the next pixel's
// words are taken only once the finishing step is done.
// Output channel (out_valid_o/out_ready_i): amplitude_o, phase_o, phase_valid_o
// sit in an output register, so the next pixel's words are taken while a result
// waits; only the finishing step holds if the previous result is still unread.
// degree_mode (APB, address 0) selects phase in degrees Q9.7 or radians Q3.13;
// write it only while idle. Reset clears the accumulators, the mode and the
// output valid; no clearing pass is needed.
module orientation_dft_phase_amplitude_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [odpa_pkg::SAMPLE_W-1:0] filter_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [odpa_pkg::SUM_W-1:0]    amplitude_o,
  output logic [odpa_pkg::PHASE_W-1:0]  phase_o,
  output logic                          phase_valid_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import odpa_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_CINIT,
    ST_CORDIC,
    ST_MLO,
    ST_MHI,
    ST_PHASE,
    ST_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [OI_W-1:0]          orient_q, orient_d;
  logic signed [ACC_W-1:0]  real_acc_q, real_acc_d;
  logic signed [ACC_W-1:0]  imag_acc_q, imag_acc_d;
  logic [SUM_W-1:0]         sum_acc_q, sum_acc_d;
  logic [SAMPLE_W-1:0]      max_q, max_d;
  logic                     mode_q, mode_d;
  logic                     out_valid_q, out_valid_d;
  logic [SUM_W-1:0]         amp_q, amp_d;
  logic [PHASE_W-1:0]       phase_q, phase_d;
  logic                     pvalid_q, pvalid_d;

  // datapath, no reset
  logic signed [CW-1:0]     x_q, x_d;
  logic signed [CW-1:0]     y_q, y_d;
  logic [31:0]              z_q, z_d;
  logic [ITER_W-1:0]        it_q, it_d;
  logic                     hzero_q, hzero_d;
  logic [63:0]              prod_q, prod_d;
  logic [MAGP_W-1:0]        mag_acc_q, mag_acc_d;

  logic signed [SAMPLE_W+COEF_W:0] prod_re, prod_im;
  logic signed [CW-1:0]     x_sh, y_sh;
  logic [CW-1:0]            x_pos;
  logic [31:0]              b_angle;
  logic [31:0]              mul_a, mul_b;
  logic [63:0]              mul_p;
  logic [MAGP_W-1:0]        mag_rnd;
  logic [MAG_W:0]           amp_wide;
  logic [63:0]              deg_rnd, rad_rnd;
  logic                     in_fire, cfg_wr, real_pos;

  assign in_ready_o    = (state_q == ST_ACCUM);
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_valid_q;
  assign amplitude_o   = amp_q;
  assign phase_o       = phase_q;
  assign phase_valid_o = pvalid_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DEGREE_MODE) ? {31'b0, mode_q} : 32'b0;

  // per-word harmonic terms
  assign prod_re = $signed({1'b0, filter_sample_i}) * $signed(COS_TAB[orient_q]);
  assign prod_im = $signed({1'b0, filter_sample_i}) * $signed(SIN_TAB[orient_q]);

  // CORDIC shifts are floor shifts
  assign x_sh = x_q >>> it_q;
  assign y_sh = y_q >>> it_q;

  assign real_pos = !real_acc_q[ACC_W-1] && (real_acc_q != '0);
  assign x_pos    = x_q[CW-1] ? '0 : x_q;
  assign b_angle  = hzero_q ? 32'b0 : (z_q + HALF_TURN);

  // shared multiplier
  always_comb begin
    mul_a = 32'b0;
    mul_b = GAIN_Q24;
    case (state_q)
      ST_MLO:   mul_a = 32'(x_pos[LO_W-1:0]);
      ST_MHI:   mul_a = 32'(x_pos[CW-1:LO_W]);
      ST_PHASE: begin
        mul_a = b_angle;
        mul_b = mode_q ? DEG_SCALE : RAD_SCALE;
      end
      default:  mul_a = 32'b0;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign mag_rnd  = mag_acc_q + (MAGP_W'(1) << (MAG_SHIFT - 1));
  assign amp_wide = (MAG_W+1)'(mag_rnd[MAGP_W-1:MAG_SHIFT]) + (MAG_W+1)'(sum_acc_q);
  assign deg_rnd  = prod_q + (64'd1 << (DEG_SHIFT - 1));
  assign rad_rnd  = prod_q + (64'd1 << (RAD_SHIFT - 1));

  always_comb begin
    state_d     = state_q;
    orient_d    = orient_q;
    real_acc_d  = real_acc_q;
    imag_acc_d  = imag_acc_q;
    sum_acc_d   = sum_acc_q;
    max_d       = max_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q && !out_ready_i;
    amp_d       = amp_q;
    phase_d     = phase_q;
    pvalid_d    = pvalid_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    it_d        = it_q;
    hzero_d     = hzero_q;
    prod_d      = prod_q;
    mag_acc_d   = mag_acc_q;

    if (cfg_wr && (paddr[2] == REG_DEGREE_MODE)) begin
      mode_d = pwdata[0];
    end

    unique case (state_q)
      ST_ACCUM: begin
        if (in_fire) begin
          real_acc_d = real_acc_q + ACC_W'(prod_re);
          imag_acc_d = imag_acc_q + ACC_W'(prod_im);
          sum_acc_d  = sum_acc_q + SUM_W'(filter_sample_i);
          if (filter_sample_i > max_q) begin
            max_d = filter_sample_i;
          end
          if (orient_q == OI_W'(NUM_ORIENT - 1)) begin
            state_d = ST_CINIT;
          end else begin
            orient_d = orient_q + 1'b1;
          end
        end
      end
      ST_CINIT: begin
        // vector (-real,-imag) folded into the right half plane
        if (real_pos) begin
          x_d = CW'(real_acc_q);
          y_d = CW'(imag_acc_q);
          z_d = HALF_TURN;
        end else begin
          x_d = -CW'(real_acc_q);
          y_d = -CW'(imag_acc_q);
          z_d = 32'b0;
        end
        hzero_d = (real_acc_q == '0) && (imag_acc_q == '0);
        it_d    = '0;
        state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (!y_q[CW-1]) begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          z_d = z_q + ATAN_TAB[it_q];
        end else begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          z_d = z_q - ATAN_TAB[it_q];
        end
        it_d = it_q + 1'b1;
        if (it_q == ITER_W'(ITERS_EFF - 1)) begin
          state_d = ST_MLO;
        end
      end
      ST_MLO: begin
        prod_d  = mul_p;
        state_d = ST_MHI;
      end
      ST_MHI: begin
        mag_acc_d = prod_q[MAGP_W-1:0];
        prod_d    = mul_p;
        state_d   = ST_PHASE;
      end
      ST_PHASE: begin
        mag_acc_d = mag_acc_q + {prod_q[MAGP_W-LO_W-1:0], LO_W'(0)};
        prod_d    = mul_p;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // hold while the previous result is still unread
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          amp_d       = (amp_wide > (MAG_W+1)'(AMP_MAX)) ? AMP_MAX : amp_wide[SUM_W-1:0];
          pvalid_d    = (max_q != '0);
          if (max_q == '0) begin
            phase_d = '0;
          end else if (mode_q) begin
            phase_d = deg_rnd[DEG_SHIFT+PHASE_W-1:DEG_SHIFT];
          end else begin
            phase_d = rad_rnd[RAD_SHIFT+PHASE_W-1:RAD_SHIFT];
          end
          real_acc_d = '0;
          imag_acc_d = '0;
          sum_acc_d  = '0;
          max_d      = '0;
          orient_d   = '0;
          state_d    = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      orient_q    <= '0;
      real_acc_q  <= '0;
      imag_acc_q  <= '0;
      sum_acc_q   <= '0;
      max_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      amp_q       <= '0;
      phase_q     <= '0;
      pvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      orient_q    <= orient_d;
      real_acc_q  <= real_acc_d;
      imag_acc_q  <= imag_acc_d;
      sum_acc_q   <= sum_acc_d;
      max_q       <= max_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      amp_q       <= amp_d;
      phase_q     <= phase_d;
      pvalid_q    <= pvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    it_q      <= it_d;
    hzero_q   <= hzero_d;
    prod_q    <= prod_d;
    mag_acc_q <= mag_acc_d;
  end

  // last word of a pixel starts the vectoring
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (orient_q == OI_W'(NUM_ORIENT - 1)) |=> state_q == ST_CINIT)
    else $error("last word did not start vectoring");

  // iteration count starts from zero
  a_iter_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CINIT |=> it_q == '0)
    else $error("CORDIC counter not cleared");

  // a fresh result only comes from the finishing step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside finish");

  // an invalid phase reads as zero
  a_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !phase_valid_o |-> phase_o == '0)
    else $error("invalid phase not zero");

endmodule
